// File: hw/rtl/plsc_pkg.sv
// Shared types, request codes and bit permutations of the protection latch scrambler.
// No dependencies; used by every module of the block.
package plsc_pkg;

  localparam int unsigned LatchWidth = 32;
  localparam int unsigned WordWidth  = 16;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Scrambler constants
  localparam logic [WordWidth-1:0] A_XOR   = 16'h0010;
  localparam logic [WordWidth-1:0] B_XOR   = 16'h0024;
  localparam logic [WordWidth-1:0] OUT_XOR = 16'h5496;

  // Latch snapshot handed from the front stage to the scrambler
  typedef struct packed {
    logic                  valid;
    logic [LatchWidth-1:0] latch;
  } snap_t;

  // First word permutation of the latch
  function automatic logic [WordWidth-1:0] perm_a(input logic [LatchWidth-1:0] x);
    logic [WordWidth-1:0] r;
    r[0]  = x[23];
    r[1]  = x[15];
    r[2]  = x[13];
    r[3]  = x[30];
    r[4]  = x[5];
    r[5]  = x[4];
    r[6]  = x[0];
    r[7]  = x[17];
    r[8]  = x[2];
    r[9]  = x[14];
    r[10] = x[26];
    r[11] = x[3];
    r[12] = x[20];
    r[13] = x[18];
    r[14] = x[11];
    r[15] = x[6];
    return r;
  endfunction

  // Second word permutation of the latch
  function automatic logic [WordWidth-1:0] perm_b(input logic [LatchWidth-1:0] x);
    logic [WordWidth-1:0] r;
    r[0]  = x[9];
    r[1]  = x[25];
    r[2]  = x[28];
    r[3]  = x[7];
    r[4]  = x[16];
    r[5]  = x[24];
    r[6]  = x[27];
    r[7]  = x[8];
    r[8]  = x[21];
    r[9]  = x[19];
    r[10] = x[10];
    r[11] = x[29];
    r[12] = x[12];
    r[13] = x[1];
    r[14] = x[22];
    r[15] = x[31];
    return r;
  endfunction

  // Output permutation; bits 6, 11, 14 and 15 stay in place
  function automatic logic [WordWidth-1:0] perm_out(input logic [WordWidth-1:0] x);
    logic [WordWidth-1:0] r;
    r[0]  = x[9];
    r[1]  = x[8];
    r[2]  = x[10];
    r[3]  = x[5];
    r[4]  = x[12];
    r[5]  = x[2];
    r[6]  = x[6];
    r[7]  = x[13];
    r[8]  = x[3];
    r[9]  = x[7];
    r[10] = x[1];
    r[11] = x[11];
    r[12] = x[4];
    r[13] = x[0];
    r[14] = x[14];
    r[15] = x[15];
    return r;
  endfunction

endpackage

// File: hw/rtl/plsc_front.sv
// Front stage: holds the 32-bit shift latch, takes items and captures a latch snapshot per read.
// Depends on plsc_pkg.
module plsc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [plsc_pkg::WordWidth-1:0]      write_data,
  input  logic                                take,
  output plsc_pkg::snap_t                     snap
);

  logic [plsc_pkg::LatchWidth-1:0] latch;
  logic                            accept;
  logic                            snap_valid;
  logic [plsc_pkg::LatchWidth-1:0] snap_latch;

  // Snapshot register frees up whenever the scrambler takes it
  assign in_ready = !snap_valid || take;
  assign accept   = in_valid && in_ready;
  assign snap     = {snap_valid, snap_latch};

  // Latch shift on write, snapshot on read
  always_ff @(posedge clk) begin
    if (rst) begin
      latch      <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept && req_type == plsc_pkg::REQ_WRITE) begin
        latch <= {latch[plsc_pkg::WordWidth-1:0], write_data};
      end
      if (accept && req_type == plsc_pkg::REQ_READ) begin
        snap_valid <= 1'b1;
      end else if (take) begin
        snap_valid <= 1'b0;
      end
    end
  end

  // Snapshot payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && req_type == plsc_pkg::REQ_READ) begin
      snap_latch <= latch;
    end
  end

endmodule

// File: hw/rtl/plsc_scramble.sv
// Scrambler stage: permutes the snapshot, subtracts, permutes again and registers the result.
// Depends on plsc_pkg.
module plsc_scramble (
  input  logic                                clk,
  input  logic                                rst,
  input  plsc_pkg::snap_t                     snap,
  output logic                                take,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [plsc_pkg::WordWidth-1:0]      read_data
);

  logic [plsc_pkg::WordWidth-1:0] a;
  logic [plsc_pkg::WordWidth-1:0] b;
  logic [plsc_pkg::WordWidth-1:0] diff;
  logic [plsc_pkg::WordWidth-1:0] perm;
  logic [plsc_pkg::WordWidth-1:0] read_data_next;

  // Result register is free when empty or being drained
  assign take = !out_valid || out_ready;

  // Scramble: two permutations, wrap-around subtract, xor, permute, byte swap
  always_comb begin
    a              = plsc_pkg::perm_a(snap.latch) ^ plsc_pkg::A_XOR;
    b              = plsc_pkg::perm_b(snap.latch) ^ plsc_pkg::B_XOR;
    diff           = (a - b) ^ plsc_pkg::OUT_XOR;
    perm           = plsc_pkg::perm_out(diff);
    read_data_next = {perm[7:0], perm[15:8]};
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= snap.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && snap.valid) begin
      read_data <= read_data_next;
    end
  end

endmodule

// File: hw/rtl/protection_latch_scrambler_top.sv
// Top level of the protection latch scrambler.
// Depends on plsc_pkg, plsc_front and plsc_scramble.

// A write item (req_type 0) shifts write_data into the low half of a 32-bit latch and gives no
// result; a read item (req_type 1) gives one result, the scrambled latch, on read_data. One item
// is taken every cycle while in_ready is high. A read result passes through the snapshot register
// of the front stage, then through the 16-bit subtract into the result register. Reads see every
// write taken before them. Back-pressure on the result side stalls the input only once both the
// snapshot and the result registers are full.
module protection_latch_scrambler_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [plsc_pkg::WordWidth-1:0]      write_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [plsc_pkg::WordWidth-1:0]      read_data
);

  plsc_pkg::snap_t snap;
  logic            take;

  plsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .write_data (write_data),
    .take       (take),
    .snap       (snap)
  );

  plsc_scramble u_scramble (
    .clk       (clk),
    .rst       (rst),
    .snap      (snap),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for protection_latch_scrambler_top.
// Depends on plsc_pkg for the request codes and scrambler constants.
// It carries its own model of the latch and scrambler and checks every read result.
module tb_top;

  // Source bit of each result bit, entry i at [5*i +: 5], bit 15 listed first
  localparam logic [79:0] A_SRC = {5'd6, 5'd11, 5'd18, 5'd20, 5'd3, 5'd26, 5'd14, 5'd2,
                                   5'd17, 5'd0, 5'd4, 5'd5, 5'd30, 5'd13, 5'd15, 5'd23};
  localparam logic [79:0] B_SRC = {5'd31, 5'd22, 5'd1, 5'd12, 5'd29, 5'd10, 5'd19, 5'd21,
                                   5'd8, 5'd27, 5'd24, 5'd16, 5'd7, 5'd28, 5'd25, 5'd9};
  localparam logic [79:0] O_SRC = {5'd15, 5'd14, 5'd0, 5'd4, 5'd11, 5'd1, 5'd7, 5'd3,
                                   5'd13, 5'd6, 5'd2, 5'd12, 5'd5, 5'd10, 5'd8, 5'd9};

  // Tracks the shift latch and the read results still owed by the block
  class read_data_predictor;
    logic [31:0] shift_latch;
    logic [15:0] pending_reads[$];
    int          errors;
    int          writes_taken;
    int          reads_taken;
    int          reads_checked;

    function new();
      shift_latch   = '0;
      errors        = 0;
      writes_taken  = 0;
      reads_taken   = 0;
      reads_checked = 0;
    endfunction

    function logic [15:0] gather(input logic [31:0] x, input logic [79:0] src);
      logic [15:0] r;
      for (int i = 0; i < 16; i++) r[i] = x[src[5*i +: 5]];
      return r;
    endfunction

    function logic [15:0] scrambled_word(input logic [31:0] latch);
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] d;
      logic [15:0] p;
      a = gather(latch, A_SRC) ^ plsc_pkg::A_XOR;
      b = gather(latch, B_SRC) ^ plsc_pkg::B_XOR;
      d = (a - b) ^ plsc_pkg::OUT_XOR;  // wraps modulo 2^16
      p = gather({16'h0000, d}, O_SRC);
      return {p[7:0], p[15:8]};
    endfunction

    // Called for every accepted input item
    function void take_item(input logic req, input logic [15:0] data);
      if (req == plsc_pkg::REQ_WRITE) begin
        shift_latch = {shift_latch[15:0], data};
        writes_taken++;
      end else begin
        pending_reads.push_back(scrambled_word(shift_latch));
        reads_taken++;
      end
    endfunction

    // Called for every accepted result item
    function void check_read(input logic [15:0] got);
      logic [15:0] want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read result %h", $time, got);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (got !== want) begin
          $display("%0t: read_data mismatch, expected %h, got %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_reads.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        req_type   = plsc_pkg::REQ_WRITE;
  logic [15:0] write_data = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [15:0] read_data;

  read_data_predictor sb;
  int          burst_left = 0;
  logic [8:0]  rx_cycle   = '0;

  protection_latch_scrambler_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side back-pressure: free flow, coin toss, sparse, then a regular stall
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 1);
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_cycle[3:0] < 4'd11);
    endcase
  end

  // Handshake monitor; results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_read(read_data);
      if (in_valid && in_ready) sb.take_item(req_type, write_data);
    end
  end

  // Data word biased towards the extremes and single-bit patterns
  function automatic logic [15:0] pick_word();
    logic [15:0] one_bit;
    one_bit = 16'h0001 << $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return one_bit;
      3: return ~one_bit;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one item and hold it until taken; then maybe drop valid for a gap
  task automatic send_item(input logic req, input logic [15:0] data);
    int gap;
    in_valid   <= 1'b1;
    req_type   <= req;
    write_data <= data;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int n_sent;
    int waited;
    int n_wr;
    int n_rd;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: read of the reset latch, extremes, ignored data on reads
    send_item(plsc_pkg::REQ_READ, 16'hffff);
    send_item(plsc_pkg::REQ_READ, 16'h0000);
    send_item(plsc_pkg::REQ_WRITE, 16'hffff);
    send_item(plsc_pkg::REQ_READ, 16'h5a5a);
    send_item(plsc_pkg::REQ_WRITE, 16'hffff);
    send_item(plsc_pkg::REQ_READ, 16'h0000);
    send_item(plsc_pkg::REQ_WRITE, 16'h0000);
    send_item(plsc_pkg::REQ_READ, 16'hffff);
    send_item(plsc_pkg::REQ_WRITE, 16'h0000);
    send_item(plsc_pkg::REQ_READ, 16'h0000);
    send_item(plsc_pkg::REQ_WRITE, 16'h8000);
    send_item(plsc_pkg::REQ_WRITE, 16'h0001);
    send_item(plsc_pkg::REQ_READ, 16'h1234);
    send_item(plsc_pkg::REQ_WRITE, 16'haaaa);
    send_item(plsc_pkg::REQ_WRITE, 16'h5555);
    send_item(plsc_pkg::REQ_READ, 16'h0000);
    send_item(plsc_pkg::REQ_READ, 16'hffff);
    send_item(plsc_pkg::REQ_WRITE, 16'h7fff);
    send_item(plsc_pkg::REQ_WRITE, 16'hfffe);
    send_item(plsc_pkg::REQ_READ, 16'h0000);

    // Random: short runs of writes followed by one or two reads
    n_sent = 0;
    while (n_sent < 600) begin
      n_wr = $urandom_range(0, 3);
      n_rd = $urandom_range(1, 2);
      repeat (n_wr) send_item(plsc_pkg::REQ_WRITE, pick_word());
      repeat (n_rd) send_item(plsc_pkg::REQ_READ, 16'($urandom));
      n_sent += n_wr + n_rd;
    end
    in_valid <= 1'b0;

    // Drain, then a few cycles for anything stray
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d read results never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("Took %0d writes and %0d reads; %0d read results checked, %0d errors.",
             sb.writes_taken, sb.reads_taken, sb.reads_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("** protection_latch_scrambler_top: PASSED **");
    end else begin
      $display("** protection_latch_scrambler_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("** protection_latch_scrambler_top: FAILED **");
    $finish;
  end

endmodule
